// ===== src/mdc_pkg.sv =====
// Shared types and constants for the message deframer and checker.
`timescale 1ns / 1ps

package mdc_pkg;

  localparam logic [31:0] MAGIC_VALUE      = 32'h4D54_5001;
  localparam logic [63:0] HEADER_BYTES     = 64'd16;
  localparam logic [15:0] MAX_LEN_RESET    = 16'd4096;
  localparam logic [3:0]  HEADER_LAST_IDX  = 4'd15;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_MAGIC = 2'd1,
    STATUS_TOO_LONG  = 2'd2,
    STATUS_BAD_SUM   = 2'd3
  } frame_status_t;

  typedef enum logic [1:0] {
    WORD_MAGIC  = 2'd0,
    WORD_TYPE   = 2'd1,
    WORD_LENGTH = 2'd2,
    WORD_SUM    = 2'd3
  } header_word_t;

  typedef struct packed {
    logic [7:0]    payload_byte;
    logic          has_byte;
    logic          end_of_frame;
    frame_status_t frame_status;
    logic [31:0]   message_type;
    logic [15:0]   payload_length;
    logic [63:0]   good_message_count;
    logic [63:0]   good_byte_count;
  } result_t;

endpackage

// ===== src/message_deframer_checker.sv =====
// Top level: length-prefixed message deframer with header and checksum checks.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid, in_stall, rx_byte) carries one link byte per transfer.
//   Output channel (out_valid, out_stall, payload and status fields) carries one
//   result per transfer. Header bytes 1..15 give no result; the 16th gives one only
//   on bad magic, too long or zero length. Every payload byte gives one result; the
//   last one carries end_of_frame and the checksum status.
//   Each result is registered in the output register, or in skid while it stalls.
//   Throughput: one byte per cycle while in_stall is low; the byte is fully
//   processed between the input handshake and the result register, with one skid
//   register behind the output. A stalled output holds its result; the next result
//   goes to the skid register and in_stall rises until the output drains.
//   cfg_wen/cfg_wdata write max_payload_len at any edge; write it while idle.
//   Reset (rst, synchronous) clears the parser, counters and the valid flags of
//   both output registers and sets max_payload_len to 4096.
module message_deframer_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  payload_byte,
  output logic        has_byte,
  output logic        end_of_frame,
  output logic [1:0]  frame_status,
  output logic [31:0] message_type,
  output logic [15:0] payload_length,
  output logic [63:0] good_message_count,
  output logic [63:0] good_byte_count
);
  import mdc_pkg::*;

  logic [15:0] max_payload_len;
  logic        in_payload, in_payload_next;
  logic [3:0]  header_index, header_index_next;
  logic [31:0] magic_word, magic_word_next;
  logic [31:0] type_word, type_word_next;
  logic [31:0] length_word, length_word_next;
  logic [31:0] expected_sum, expected_sum_next;
  logic [15:0] payload_remaining, payload_remaining_next;
  logic [31:0] running_sum, running_sum_next;
  logic [63:0] message_counter, message_counter_next;
  logic [63:0] byte_counter, byte_counter_next;

  logic        in_accept;
  logic        gen_valid;
  result_t     gen;
  logic        res_valid;
  result_t     res;
  logic        skid_valid;
  result_t     skid;

  logic [31:0] lane_mask;
  logic [31:0] lane_part;
  logic        count_good;

  assign in_stall  = skid_valid;
  assign in_accept = in_valid & ~in_stall;

  always_comb begin
    in_payload_next        = in_payload;
    header_index_next      = header_index;
    magic_word_next        = magic_word;
    type_word_next         = type_word;
    length_word_next       = length_word;
    expected_sum_next      = expected_sum;
    payload_remaining_next = payload_remaining;
    running_sum_next       = running_sum;
    count_good             = 1'b0;
    gen_valid              = 1'b0;
    gen                    = '0;
    lane_mask              = ~(32'hFF << {header_index[1:0], 3'b000});
    lane_part              = {24'd0, rx_byte} << {header_index[1:0], 3'b000};
    if (in_payload) begin
      running_sum_next       = {running_sum[30:0], running_sum[31]} ^ {24'd0, rx_byte};
      payload_remaining_next = payload_remaining - 16'd1;
      gen_valid              = 1'b1;
      gen.payload_byte       = rx_byte;
      gen.has_byte           = 1'b1;
      if (payload_remaining == 16'd1) begin
        in_payload_next      = 1'b0;
        gen.end_of_frame     = 1'b1;
        if (running_sum_next == expected_sum) begin
          gen.frame_status = STATUS_OK;
          count_good       = 1'b1;
        end else begin
          gen.frame_status = STATUS_BAD_SUM;
        end
      end
    end else begin
      header_index_next = header_index + 4'd1;
      unique case (header_word_t'(header_index[3:2]))
        WORD_MAGIC:  magic_word_next   = (magic_word & lane_mask) | lane_part;
        WORD_TYPE:   type_word_next    = (type_word & lane_mask) | lane_part;
        WORD_LENGTH: length_word_next  = (length_word & lane_mask) | lane_part;
        WORD_SUM:    expected_sum_next = (expected_sum & lane_mask) | lane_part;
        default:     expected_sum_next = expected_sum;
      endcase
      if (header_index == HEADER_LAST_IDX) begin
        priority if (magic_word != MAGIC_VALUE) begin
          gen_valid        = 1'b1;
          gen.end_of_frame = 1'b1;
          gen.frame_status = STATUS_BAD_MAGIC;
        end else if (length_word > {16'd0, max_payload_len}) begin
          gen_valid        = 1'b1;
          gen.end_of_frame = 1'b1;
          gen.frame_status = STATUS_TOO_LONG;
        end else if (length_word == 32'd0) begin
          gen_valid        = 1'b1;
          gen.end_of_frame = 1'b1;
          gen.frame_status = STATUS_OK;
          count_good       = 1'b1;
        end else begin
          in_payload_next        = 1'b1;
          payload_remaining_next = length_word[15:0];
          running_sum_next       = '0;
        end
      end
    end
    message_counter_next = message_counter;
    byte_counter_next    = byte_counter;
    if (count_good) begin
      message_counter_next = message_counter + 64'd1;
      byte_counter_next    = byte_counter + HEADER_BYTES + {32'd0, length_word};
    end
    if (gen.end_of_frame) begin
      gen.message_type   = type_word;
      gen.payload_length = length_word[15:0];
    end
    gen.good_message_count = message_counter_next;
    gen.good_byte_count    = byte_counter_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload_len <= MAX_LEN_RESET;
    end else if (cfg_wen) begin
      max_payload_len <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_payload        <= 1'b0;
      header_index      <= '0;
      magic_word        <= '0;
      type_word         <= '0;
      length_word       <= '0;
      expected_sum      <= '0;
      payload_remaining <= '0;
      running_sum       <= '0;
      message_counter   <= '0;
      byte_counter      <= '0;
    end else if (in_accept) begin
      in_payload        <= in_payload_next;
      header_index      <= header_index_next;
      magic_word        <= magic_word_next;
      type_word         <= type_word_next;
      length_word       <= length_word_next;
      expected_sum      <= expected_sum_next;
      payload_remaining <= payload_remaining_next;
      running_sum       <= running_sum_next;
      message_counter   <= message_counter_next;
      byte_counter      <= byte_counter_next;
    end
  end

  // Advance the output register when it is free; park a new result in skid otherwise.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!res_valid || !out_stall) begin
      if (skid_valid) begin
        res_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        res_valid <= in_accept & gen_valid;
      end
    end else if (in_accept && gen_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!res_valid || !out_stall) begin
      if (skid_valid) begin
        res <= skid;
      end else begin
        res <= gen;
      end
    end else if (in_accept && gen_valid) begin
      skid <= gen;
    end
  end

  assign out_valid          = res_valid;
  assign payload_byte       = res.payload_byte;
  assign has_byte           = res.has_byte;
  assign end_of_frame       = res.end_of_frame;
  assign frame_status       = res.frame_status;
  assign message_type       = res.message_type;
  assign payload_length     = res.payload_length;
  assign good_message_count = res.good_message_count;
  assign good_byte_count    = res.good_byte_count;

endmodule

// ===== test/tb_message_deframer_checker.sv =====
// Testbench for message_deframer_checker: framed byte traffic checked against a predictor.
`timescale 1ns / 1ps

module tb_message_deframer_checker;
  import mdc_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  payload_byte;
  logic        has_byte;
  logic        end_of_frame;
  logic [1:0]  frame_status;
  logic [31:0] message_type;
  logic [15:0] payload_length;
  logic [63:0] good_message_count;
  logic [63:0] good_byte_count;

  message_deframer_checker dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_wen            (cfg_wen),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .rx_byte            (rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .payload_byte       (payload_byte),
    .has_byte           (has_byte),
    .end_of_frame       (end_of_frame),
    .frame_status       (frame_status),
    .message_type       (message_type),
    .payload_length     (payload_length),
    .good_message_count (good_message_count),
    .good_byte_count    (good_byte_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Deframer state as predicted from the accepted bytes
  logic        in_body = 1'b0;
  logic [3:0]  hdr_idx = '0;
  logic [31:0] hdr_w [4];
  logic [15:0] body_left = '0;
  logic [31:0] body_sum = '0;
  logic [63:0] msg_cnt = '0;
  logic [63:0] byte_cnt = '0;
  logic [15:0] max_len = MAX_LEN_RESET;

  result_t predicted_results [$];
  int      fail_count = 0;
  int      sent_count = 0;
  int      idle_pct = 22;
  int      hold_req = 0;
  int      hold_left = 0;

  function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
    logic [1:0]    word;
    logic [1:0]    lane;
    frame_status_t st;
    bit            emit;
    bit            eof;
    r = '0;
    st = STATUS_OK;
    emit = 1'b0;
    eof = 1'b0;
    if (in_body) begin
      body_sum = {body_sum[30:0], body_sum[31]} ^ {24'd0, b};
      body_left = body_left - 16'd1;
      emit = 1'b1;
      r.payload_byte = b;
      r.has_byte = 1'b1;
      if (body_left == 16'd0) begin
        in_body = 1'b0;
        eof = 1'b1;
        st = (body_sum == hdr_w[WORD_SUM]) ? STATUS_OK : STATUS_BAD_SUM;
      end
    end else begin
      word = hdr_idx[3:2];
      lane = hdr_idx[1:0];
      hdr_w[word][{lane, 3'b000} +: 8] = b;
      if (hdr_idx == HEADER_LAST_IDX) begin
        emit = 1'b1;
        eof = 1'b1;
        if (hdr_w[WORD_MAGIC] != MAGIC_VALUE) begin
          st = STATUS_BAD_MAGIC;
        end else if (hdr_w[WORD_LENGTH] > {16'd0, max_len}) begin
          st = STATUS_TOO_LONG;
        end else if (hdr_w[WORD_LENGTH] != 32'd0) begin
          emit = 1'b0;
          eof = 1'b0;
          in_body = 1'b1;
          body_left = hdr_w[WORD_LENGTH][15:0];
          body_sum = '0;
        end
      end
      hdr_idx = hdr_idx + 4'd1;
    end
    if (eof) begin
      if (st == STATUS_OK) begin
        msg_cnt = msg_cnt + 64'd1;
        byte_cnt = byte_cnt + HEADER_BYTES + {32'd0, hdr_w[WORD_LENGTH]};
      end
      r.end_of_frame = 1'b1;
      r.frame_status = st;
      r.message_type = hdr_w[WORD_TYPE];
      r.payload_length = hdr_w[WORD_LENGTH][15:0];
    end
    r.good_message_count = msg_cnt;
    r.good_byte_count = byte_cnt;
    return emit;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    result_t r;
    bit      taken;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    if (deframe_byte(b, r)) predicted_results.push_back(r);
    sent_count++;
  endtask

  task automatic send_word(input logic [31:0] w);
    for (int k = 0; k < 4; k++) send_byte(w[8*k +: 8]);
  endtask

  task automatic send_frame(input logic [31:0] magic, input logic [31:0] kind,
                            input logic [31:0] len, input bit bad_sum, input int cut);
    logic [7:0]  body [$];
    logic [31:0] sum;
    logic [7:0]  b;
    int          n;
    sum = '0;
    n = (magic == MAGIC_VALUE && len <= {16'd0, max_len}) ? int'(len) : 0;
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom);
      body.push_back(b);
      sum = {sum[30:0], sum[31]} ^ {24'd0, b};
    end
    if (bad_sum) sum = sum ^ (32'd1 << $urandom_range(31));
    send_word(magic);
    send_word(kind);
    send_word(len);
    send_word(sum);
    for (int i = 0; i < n - cut; i++) send_byte(body[i]);
  endtask

  // Pad until the parser expects the first byte of a header again
  task automatic resync();
    while (in_body || hdr_idx != 4'd0) send_byte(8'($urandom));
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max_len(input logic [15:0] v);
    quiesce();
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 1'b0;
    max_len = v;
  endtask

  task automatic test_directed_frames();
    send_frame(MAGIC_VALUE, 32'h0000_0000, 32'd1, 1'b0, 0);
    send_frame(MAGIC_VALUE, 32'hFFFF_FFFF, 32'd5, 1'b0, 0);
    send_frame(MAGIC_VALUE, 32'h1234_5678, 32'd0, 1'b0, 0);
    send_frame(MAGIC_VALUE ^ 32'h8000_0000, 32'd7, 32'd3, 1'b0, 0);
    send_frame(MAGIC_VALUE, 32'd2, 32'd4097, 1'b0, 0);
    send_frame(MAGIC_VALUE, 32'd3, 32'h8000_0004, 1'b0, 0);
    send_frame(MAGIC_VALUE, 32'd4, 32'd6, 1'b1, 0);
    send_frame(MAGIC_VALUE, 32'd5, 32'd2, 1'b0, 0);
    repeat (5) send_byte(8'hFF);
    resync();
    send_frame(MAGIC_VALUE, 32'd6, 32'd3, 1'b0, 0);
  endtask

  task automatic test_output_hold_off();
    quiesce();
    idle_pct = 0;
    hold_req = 250;
    send_frame(MAGIC_VALUE, 32'hA5A5_0F0F, 32'd40, 1'b0, 0);
    quiesce();
    idle_pct = 22;
  endtask

  task automatic test_length_limits();
    write_max_len(16'd0);
    send_frame(MAGIC_VALUE, 32'd10, 32'd0, 1'b0, 0);
    send_frame(MAGIC_VALUE, 32'd11, 32'd1, 1'b0, 0);
    write_max_len(16'd16);
    send_frame(MAGIC_VALUE, 32'd12, 32'd16, 1'b0, 0);
    send_frame(MAGIC_VALUE, 32'd13, 32'd17, 1'b0, 0);
    write_max_len(16'hFFFF);
    send_frame(MAGIC_VALUE, 32'd14, 32'h0001_0000, 1'b0, 0);
    send_frame(MAGIC_VALUE, 32'd15, 32'd9, 1'b0, 0);
    write_max_len(MAX_LEN_RESET);
  endtask

  task automatic random_frame();
    int          pick;
    int          top;
    logic [31:0] len;
    pick = $urandom_range(99);
    top = (max_len < 16'd20) ? int'(max_len) : 20;
    len = (top == 0) ? 32'd0 : 32'($urandom_range(top, 1));
    if (pick < 60) begin
      send_frame(MAGIC_VALUE, $urandom, len, 1'b0, 0);
    end else if (pick < 68) begin
      send_frame(MAGIC_VALUE, $urandom, 32'd0, 1'($urandom_range(1)), 0);
    end else if (pick < 75) begin
      send_frame(MAGIC_VALUE, $urandom, len, 1'b1, 0);
    end else if (pick < 81) begin
      send_frame(pick[0] ? $urandom : MAGIC_VALUE ^ (32'd1 << $urandom_range(31)),
                 $urandom, len, 1'b0, 0);
    end else if (pick < 87) begin
      send_frame(MAGIC_VALUE, $urandom,
                 pick[0] ? {16'd0, max_len} + 32'd1 + 32'($urandom_range(3))
                         : ($urandom | 32'h0001_0000), 1'b0, 0);
    end else if (pick < 93) begin
      if (len > 32'd1) send_frame(MAGIC_VALUE, $urandom, len, 1'b0,
                                  $urandom_range(int'(len) - 1, 1));
    end else begin
      repeat ($urandom_range(20, 1)) send_byte(8'($urandom));
    end
    resync();
  endtask

  task automatic test_random_traffic();
    int phase_end;
    for (int p = 0; p < 6; p++) begin
      case (p % 3)
        0: write_max_len(16'($urandom_range(40)));
        1: write_max_len(16'hFFFF);
        default: write_max_len(16'($urandom_range(4096, 20)));
      endcase
      idle_pct = (p == 2 || p == 4) ? 0 : 22;
      phase_end = sent_count + 225;
      while (sent_count < phase_end) random_frame();
    end
    idle_pct = 22;
  endtask

  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  // Compare each output transfer with the oldest prediction
  always @(negedge clk) begin : check_transfer
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (predicted_results.size() == 0) begin
        $error("result with none predicted: payload_byte %0h end_of_frame %0b",
               payload_byte, end_of_frame);
        fail_count++;
      end else begin
        want = predicted_results.pop_front();
        check_field("payload_byte", want.payload_byte, payload_byte);
        check_field("has_byte", want.has_byte, has_byte);
        check_field("end_of_frame", want.end_of_frame, end_of_frame);
        check_field("frame_status", want.frame_status, frame_status);
        check_field("message_type", want.message_type, message_type);
        check_field("payload_length", want.payload_length, payload_length);
        check_field("good_message_count", want.good_message_count, good_message_count);
        check_field("good_byte_count", want.good_byte_count, good_byte_count);
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed_frames();
    test_output_hold_off();
    test_length_limits();
    test_random_traffic();
    quiesce();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
